@@ rtl/core/mst_pkg.sv @@
// shared types and constants of the multi-slot countdown timer
// no dependencies; imported by the front, back and top level
package mst_pkg;

	localparam int IDX_W      = 4;
	localparam int IVAL_W     = 16;
	localparam int MASK_W     = 12;
	localparam int TICK_W     = 32;
	localparam int SEC_W      = 23;
	localparam int SUB_W      = 10;
	localparam int MS_PER_SEC = 1000;

	typedef enum logic [1:0] {
		OP_TICK       = 2'd0,
		OP_ADD        = 2'd1,
		OP_CHANGE     = 2'd2,
		OP_INVALIDATE = 2'd3
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [IDX_W-1:0]  slot;
		logic              in_range;
		logic [IVAL_W-1:0] interval;
		logic              one_shot;
	} cmd_t;

	typedef struct packed {
		logic [MASK_W-1:0] fired_mask;
		logic [IDX_W-1:0]  granted_slot;
		logic              table_full;
	} res_t;

endpackage

@@ rtl/core/multi_slot_countdown_timer.sv @@
// multi-slot countdown timer top level: front queue plus back slot engine
// depends on mst_pkg, mst_front, mst_back
//
// A command transaction is taken at a clock edge where start is high and
// busy is low. opcode selects tick, add slot, change interval or invalidate
// slot; slot_index, interval and one_shot go with it. Each transaction gives
// exactly one result, shown for one cycle with done high: fired_mask (tick),
// granted_slot and table_full (add), and the uptime in ticks and seconds.
// Commands wait in a two-entry queue; busy is high while it holds two.
// Add, change and invalidate are taken from the queue when the engine is
// idle and give their result through the registered done. A tick visits
// one slot per cycle through a single countdown read/write port, in slot
// order, and the engine takes no other command from the queue until the
// scan has passed the last slot; a new tick does not start until the
// previous scan is through.
// Reset clears all slots, the uptime and the queue; the result ports are
// not meaningful until the first done. The receiver cannot stall: each
// result is consumed in the cycle it is shown.
module multi_slot_countdown_timer import mst_pkg::*; #(
	parameter int SLOT_COUNT  = 12,
	parameter int PERIOD_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        opcode,
	input  logic [IDX_W-1:0]  slot_index,
	input  logic [IVAL_W-1:0] interval,
	input  logic              one_shot,
	output logic              done,
	output logic [MASK_W-1:0] fired_mask,
	output logic [IDX_W-1:0]  granted_slot,
	output logic              table_full,
	output logic [TICK_W-1:0] uptime_ms,
	output logic [SEC_W-1:0]  uptime_seconds
);

	logic pop;
	logic avail;
	cmd_t cmd;
	res_t res;

	mst_front #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.opcode    (opcode),
		.slot_index(slot_index),
		.interval  (interval),
		.one_shot  (one_shot),
		.pop       (pop),
		.avail     (avail),
		.cmd       (cmd)
	);

	mst_back #(
		.SLOT_COUNT (SLOT_COUNT),
		.PERIOD_BITS(PERIOD_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.avail         (avail),
		.cmd           (cmd),
		.pop           (pop),
		.done          (done),
		.res           (res),
		.uptime_ms     (uptime_ms),
		.uptime_seconds(uptime_seconds)
	);

	assign fired_mask   = res.fired_mask;
	assign granted_slot = res.granted_slot;
	assign table_full   = res.table_full;

	// uptime only ever steps by one tick or wraps to zero
	a_uptime_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(uptime_ms) |-> (uptime_ms == $past(uptime_ms) + 32'd1) || (uptime_ms == '0))
		else $error("uptime jumped");

	// seconds move only together with the tick count
	a_sec_follows: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(uptime_seconds) |-> !$stable(uptime_ms))
		else $error("seconds changed without a tick");

	// a full table never reports a granted slot
	a_full_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		done && table_full |-> granted_slot == '0 && fired_mask == '0)
		else $error("full table with grant or fired bits");

	// fired bits only come from a tick, never alongside an add result
	a_fire_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && fired_mask != '0 |-> !table_full && granted_slot == '0)
		else $error("fired bits mixed with add result");

endmodule

@@ rtl/core/mst_front.sv @@
// front end: accepts command transactions, classifies them and queues them
// depends on mst_pkg
module mst_front import mst_pkg::*; #(
	parameter int SLOT_COUNT = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        opcode,
	input  logic [IDX_W-1:0]  slot_index,
	input  logic [IVAL_W-1:0] interval,
	input  logic              one_shot,
	input  logic              pop,
	output logic              avail,
	output cmd_t              cmd
);

	cmd_t       cmd_in;
	cmd_t       q_mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       do_pop;

	assign busy   = (cnt_q == 2'd2);
	assign avail  = (cnt_q != 2'd0);
	assign push   = start && !busy;
	assign do_pop = pop && avail;
	assign cmd    = q_mem_q[rd_ptr_q];

	always_comb begin
		cmd_in.op       = op_t'(opcode);
		cmd_in.slot     = slot_index;
		cmd_in.in_range = ({1'b0, slot_index} < 5'(SLOT_COUNT));
		cmd_in.interval = interval;
		cmd_in.one_shot = one_shot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !do_pop)
				cnt_q <= cnt_q + 2'd1;
			else if (!push && do_pop)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			q_mem_q[wr_ptr_q] <= cmd_in;
	end

endmodule

@@ rtl/core/mst_back.sv @@
// back end: slot table, uptime counters and the per-slot tick scan
// depends on mst_pkg
module mst_back import mst_pkg::*; #(
	parameter int SLOT_COUNT  = 12,
	parameter int PERIOD_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              avail,
	input  cmd_t              cmd,
	output logic              pop,
	output logic              done,
	output res_t              res,
	output logic [TICK_W-1:0] uptime_ms,
	output logic [SEC_W-1:0]  uptime_seconds
);

	localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SCAN = 2'b10
	} state_t;

	state_t                 state_q;
	logic [SLOT_COUNT-1:0]  valid_q;
	logic [SLOT_COUNT-1:0]  one_shot_q;
	logic [PERIOD_BITS-1:0] period_q    [SLOT_COUNT];
	logic [PERIOD_BITS-1:0] countdown_q [SLOT_COUNT];
	logic [SLOT_W-1:0]      ptr_q;
	logic [MASK_W-1:0]      fired_q;
	logic [TICK_W-1:0]      tick_q;
	logic [SUB_W-1:0]       sub_q;
	logic [SEC_W-1:0]       sec_q;
	logic                   done_q;
	res_t                   res_q;

	logic [SLOT_W-1:0]      found;
	logic                   any_free;
	logic [31:0]            ival_wide;
	logic [PERIOD_BITS-1:0] ival_cut;
	logic [PERIOD_BITS-1:0] period_new;
	logic [PERIOD_BITS-1:0] cd_dec;
	logic                   fire;
	logic                   last;
	logic [MASK_W-1:0]      fired_nxt;
	logic [SLOT_W-1:0]      cmd_slot;

	assign pop            = (state_q == S_IDLE) && avail;
	assign done           = done_q;
	assign res            = res_q;
	assign uptime_ms      = tick_q;
	assign uptime_seconds = sec_q;
	assign cmd_slot       = cmd.slot[SLOT_W-1:0];

	// lowest free slot
	always_comb begin
		found = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (!valid_q[i])
				found = SLOT_W'(i);
		end
	end
	assign any_free = !(&valid_q);

	// zero interval repaired to one
	assign ival_wide  = {16'b0, cmd.interval};
	assign ival_cut   = ival_wide[PERIOD_BITS-1:0];
	assign period_new = (ival_cut == '0) ? PERIOD_BITS'(1) : ival_cut;

	assign cd_dec    = countdown_q[ptr_q] - PERIOD_BITS'(1);
	assign fire      = valid_q[ptr_q] && (cd_dec == '0);
	assign last      = (ptr_q == SLOT_W'(SLOT_COUNT - 1));
	assign fired_nxt = fired_q | (fire ? (MASK_W'(1) << ptr_q) : MASK_W'(0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ptr_q   <= '0;
			done_q  <= 1'b0;
			valid_q <= '0;
			tick_q  <= '0;
			sub_q   <= '0;
			sec_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						unique case (cmd.op)
							OP_TICK: begin
								if (tick_q == '1) begin
									tick_q <= '0;
									sub_q  <= '0;
									sec_q  <= '0;
								end else begin
									tick_q <= tick_q + TICK_W'(1);
									if (sub_q == SUB_W'(MS_PER_SEC - 1)) begin
										sub_q <= '0;
										sec_q <= sec_q + SEC_W'(1);
									end else begin
										sub_q <= sub_q + SUB_W'(1);
									end
								end
								ptr_q   <= '0;
								state_q <= S_SCAN;
							end
							OP_ADD: begin
								if (any_free)
									valid_q[found] <= 1'b1;
								done_q <= 1'b1;
							end
							OP_CHANGE: begin
								done_q <= 1'b1;
							end
							OP_INVALIDATE: begin
								if (cmd.in_range)
									valid_q[cmd_slot] <= 1'b0;
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (fire && one_shot_q[ptr_q])
						valid_q[ptr_q] <= 1'b0;
					if (last) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						ptr_q <= ptr_q + SLOT_W'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && pop) begin
			unique case (cmd.op)
				OP_TICK: begin
					fired_q <= '0;
				end
				OP_ADD: begin
					if (any_free) begin
						period_q[found]    <= period_new;
						countdown_q[found] <= period_new;
						one_shot_q[found]  <= cmd.one_shot;
					end
					res_q.fired_mask   <= '0;
					res_q.granted_slot <= any_free ? IDX_W'(found) : '0;
					res_q.table_full   <= !any_free;
				end
				OP_CHANGE: begin
					if (cmd.in_range) begin
						period_q[cmd_slot]    <= period_new;
						countdown_q[cmd_slot] <= period_new;
					end
					res_q <= '0;
				end
				OP_INVALIDATE: begin
					res_q <= '0;
				end
			endcase
		end else if (state_q == S_SCAN) begin
			if (valid_q[ptr_q])
				countdown_q[ptr_q] <= fire ? period_q[ptr_q] : cd_dec;
			fired_q <= fired_nxt;
			if (last) begin
				res_q.fired_mask   <= fired_nxt;
				res_q.granted_slot <= '0;
				res_q.table_full   <= 1'b0;
			end
		end
	end

endmodule
